/* src/sha512_hash_engine_defines.svh */
// ----------------------------------------------------------------------------
// SHA-512 hash engine assertion macros
// Concurrent assertion forms used by the engine's controller.
// ----------------------------------------------------------------------------
`ifndef SHA512_HASH_ENGINE_DEFINES_SVH
`define SHA512_HASH_ENGINE_DEFINES_SVH

// The consequent holds in the same cycle as the antecedent.
`define S512_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent holds in the cycle after the antecedent.
`define S512_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* src/s512_pkg.sv */
// ----------------------------------------------------------------------------
// SHA-512 engine package
// Types, constants and round functions shared by controller and datapath.
// ----------------------------------------------------------------------------
package s512_pkg;

    localparam int BLOCK_WORDS = 16;
    localparam int HASH_WORDS  = 8;
    localparam logic [6:0] LAST_ROUND   = 7'd79;
    localparam logic [6:0] MAX_BYTES    = 7'd64;
    localparam logic [3:0] WORD_BYTES   = 4'd8;
    localparam logic [3:0] IDX_LEN_HI   = 4'd14;
    localparam logic [3:0] IDX_LEN_LO   = 4'd15;
    localparam logic [63:0] PAD_WORD    = 64'h8000_0000_0000_0000;

    localparam logic [63:0] IV [HASH_WORDS] = '{
        64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
        64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
        64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
    };

    typedef struct packed {
        logic write_in;
        logic write_pad;
        logic cinit;
        logic round;
        logic cfin;
        logic take;
        logic restart;
    } t_cmd;

    typedef struct packed {
        logic idx_last;
        logic hi_done;
        logic round_last;
        logic out_last;
    } t_status;

    function automatic logic [63:0] rotr(input logic [63:0] x, input int n);
        rotr = (x >> n) | (x << (64 - n));
    endfunction

    function automatic logic [63:0] bsig0(input logic [63:0] x);
        bsig0 = rotr(x, 28) ^ rotr(x, 34) ^ rotr(x, 39);
    endfunction

    function automatic logic [63:0] bsig1(input logic [63:0] x);
        bsig1 = rotr(x, 14) ^ rotr(x, 18) ^ rotr(x, 41);
    endfunction

    function automatic logic [63:0] ssig0(input logic [63:0] x);
        ssig0 = rotr(x, 1) ^ rotr(x, 8) ^ (x >> 7);
    endfunction

    function automatic logic [63:0] ssig1(input logic [63:0] x);
        ssig1 = rotr(x, 19) ^ rotr(x, 61) ^ (x >> 6);
    endfunction

    function automatic logic [63:0] round_k(input logic [6:0] r);
        case (r)
            7'd0:  round_k = 64'h428a2f98d728ae22; 7'd1:  round_k = 64'h7137449123ef65cd;
            7'd2:  round_k = 64'hb5c0fbcfec4d3b2f; 7'd3:  round_k = 64'he9b5dba58189dbbc;
            7'd4:  round_k = 64'h3956c25bf348b538; 7'd5:  round_k = 64'h59f111f1b605d019;
            7'd6:  round_k = 64'h923f82a4af194f9b; 7'd7:  round_k = 64'hab1c5ed5da6d8118;
            7'd8:  round_k = 64'hd807aa98a3030242; 7'd9:  round_k = 64'h12835b0145706fbe;
            7'd10: round_k = 64'h243185be4ee4b28c; 7'd11: round_k = 64'h550c7dc3d5ffb4e2;
            7'd12: round_k = 64'h72be5d74f27b896f; 7'd13: round_k = 64'h80deb1fe3b1696b1;
            7'd14: round_k = 64'h9bdc06a725c71235; 7'd15: round_k = 64'hc19bf174cf692694;
            7'd16: round_k = 64'he49b69c19ef14ad2; 7'd17: round_k = 64'hefbe4786384f25e3;
            7'd18: round_k = 64'h0fc19dc68b8cd5b5; 7'd19: round_k = 64'h240ca1cc77ac9c65;
            7'd20: round_k = 64'h2de92c6f592b0275; 7'd21: round_k = 64'h4a7484aa6ea6e483;
            7'd22: round_k = 64'h5cb0a9dcbd41fbd4; 7'd23: round_k = 64'h76f988da831153b5;
            7'd24: round_k = 64'h983e5152ee66dfab; 7'd25: round_k = 64'ha831c66d2db43210;
            7'd26: round_k = 64'hb00327c898fb213f; 7'd27: round_k = 64'hbf597fc7beef0ee4;
            7'd28: round_k = 64'hc6e00bf33da88fc2; 7'd29: round_k = 64'hd5a79147930aa725;
            7'd30: round_k = 64'h06ca6351e003826f; 7'd31: round_k = 64'h142929670a0e6e70;
            7'd32: round_k = 64'h27b70a8546d22ffc; 7'd33: round_k = 64'h2e1b21385c26c926;
            7'd34: round_k = 64'h4d2c6dfc5ac42aed; 7'd35: round_k = 64'h53380d139d95b3df;
            7'd36: round_k = 64'h650a73548baf63de; 7'd37: round_k = 64'h766a0abb3c77b2a8;
            7'd38: round_k = 64'h81c2c92e47edaee6; 7'd39: round_k = 64'h92722c851482353b;
            7'd40: round_k = 64'ha2bfe8a14cf10364; 7'd41: round_k = 64'ha81a664bbc423001;
            7'd42: round_k = 64'hc24b8b70d0f89791; 7'd43: round_k = 64'hc76c51a30654be30;
            7'd44: round_k = 64'hd192e819d6ef5218; 7'd45: round_k = 64'hd69906245565a910;
            7'd46: round_k = 64'hf40e35855771202a; 7'd47: round_k = 64'h106aa07032bbd1b8;
            7'd48: round_k = 64'h19a4c116b8d2d0c8; 7'd49: round_k = 64'h1e376c085141ab53;
            7'd50: round_k = 64'h2748774cdf8eeb99; 7'd51: round_k = 64'h34b0bcb5e19b48a8;
            7'd52: round_k = 64'h391c0cb3c5c95a63; 7'd53: round_k = 64'h4ed8aa4ae3418acb;
            7'd54: round_k = 64'h5b9cca4f7763e373; 7'd55: round_k = 64'h682e6ff3d6b2b8a3;
            7'd56: round_k = 64'h748f82ee5defb2fc; 7'd57: round_k = 64'h78a5636f43172f60;
            7'd58: round_k = 64'h84c87814a1f0ab72; 7'd59: round_k = 64'h8cc702081a6439ec;
            7'd60: round_k = 64'h90befffa23631e28; 7'd61: round_k = 64'ha4506cebde82bde9;
            7'd62: round_k = 64'hbef9a3f7b2c67915; 7'd63: round_k = 64'hc67178f2e372532b;
            7'd64: round_k = 64'hca273eceea26619c; 7'd65: round_k = 64'hd186b8c721c0c207;
            7'd66: round_k = 64'heada7dd6cde0eb1e; 7'd67: round_k = 64'hf57d4f7fee6ed178;
            7'd68: round_k = 64'h06f067aa72176fba; 7'd69: round_k = 64'h0a637dc5a2c898a6;
            7'd70: round_k = 64'h113f9804bef90dae; 7'd71: round_k = 64'h1b710b35131c471b;
            7'd72: round_k = 64'h28db77f523047d84; 7'd73: round_k = 64'h32caab7b40c72493;
            7'd74: round_k = 64'h3c9ebe0a15c9bebc; 7'd75: round_k = 64'h431d67c49c100d4c;
            7'd76: round_k = 64'h4cc5d4becb3e42b6; 7'd77: round_k = 64'h597f299cfc657e2a;
            7'd78: round_k = 64'h5fcb6fab3ad6faec; 7'd79: round_k = 64'h6c44198c4a475817;
            default: round_k = 64'h0;
        endcase
    endfunction

endpackage

/* src/s512_ctrl.sv */
// ----------------------------------------------------------------------------
// SHA-512 engine controller
// Sequences word intake, padding, compression and digest output.
// ----------------------------------------------------------------------------
`include "sha512_hash_engine_defines.svh"

module s512_ctrl
    import s512_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_data_valid,
    input  logic    i_last_of_message,
    input  logic    i_digest_ready,
    input  t_status i_status,
    output logic    o_data_ready,
    output logic    o_digest_valid,
    output t_cmd    o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PAD   = 3'd1;
    localparam logic [2:0] S_CINIT = 3'd2;
    localparam logic [2:0] S_ROUND = 3'd3;
    localparam logic [2:0] S_CFIN  = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0] r_state, n_state;
    logic       r_padding, n_padding;
    logic       r_done, n_done;
    logic       in_acc;
    logic       out_acc;

    assign o_data_ready   = (r_state == S_IDLE);
    assign o_digest_valid = (r_state == S_OUT);
    assign in_acc  = o_data_ready & i_data_valid;
    assign out_acc = o_digest_valid & i_digest_ready;

    always_comb begin
        n_state   = r_state;
        n_padding = r_padding;
        n_done    = r_done;
        o_cmd     = '0;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    o_cmd.write_in = 1'b1;
                    if (i_last_of_message) begin
                        n_padding = 1'b1;
                    end
                    if (i_status.idx_last) begin
                        n_state = S_CINIT;
                    end else if (i_last_of_message) begin
                        n_state = S_PAD;
                    end
                end
            end
            S_PAD: begin
                o_cmd.write_pad = 1'b1;
                if (i_status.idx_last) begin
                    n_done  = i_status.hi_done;
                    n_state = S_CINIT;
                end
            end
            S_CINIT: begin
                o_cmd.cinit = 1'b1;
                n_state     = S_ROUND;
            end
            S_ROUND: begin
                o_cmd.round = 1'b1;
                if (i_status.round_last) begin
                    n_state = S_CFIN;
                end
            end
            S_CFIN: begin
                o_cmd.cfin = 1'b1;
                if (r_done) begin
                    n_state = S_OUT;
                end else if (r_padding) begin
                    n_state = S_PAD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_OUT: begin
                if (out_acc) begin
                    o_cmd.take = 1'b1;
                    if (i_status.out_last) begin
                        o_cmd.restart = 1'b1;
                        n_padding     = 1'b0;
                        n_done        = 1'b0;
                        n_state       = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_padding <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_padding <= n_padding;
            r_done    <= n_done;
        end
    end

    `S512_ASSERT_NEXT(a_full_block_compresses, i_clk, i_rst_n,
        in_acc && i_status.idx_last, r_state == S_CINIT)
    `S512_ASSERT_NEXT(a_rounds_end_in_final, i_clk, i_rst_n,
        r_state == S_ROUND && i_status.round_last, r_state == S_CFIN)
    `S512_ASSERT_SAME(a_output_only_when_done, i_clk, i_rst_n,
        o_digest_valid, r_done && r_padding && !o_data_ready)

endmodule

/* src/s512_datapath.sv */
// ----------------------------------------------------------------------------
// SHA-512 engine datapath
// Message schedule window, round unit, chaining value, counters and digest.
// ----------------------------------------------------------------------------
module s512_datapath
    import s512_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  logic [63:0] i_data_word,
    input  logic [3:0]  i_byte_count,
    input  logic        i_last_of_message,
    input  logic        i_cfg_write,
    input  logic [6:0]  i_cfg_digest_bytes,
    output t_status     o_status,
    output logic [63:0] o_digest_word,
    output logic [3:0]  o_digest_valid_bytes,
    output logic        o_last_digest_word
);

    logic [63:0] r_w [BLOCK_WORDS];
    logic [63:0] r_v [HASH_WORDS];
    logic [63:0] r_h [HASH_WORDS];
    logic [63:0] r_cnt_hi, r_cnt_lo;
    logic [3:0]  r_idx;
    logic        r_need80;
    logic        r_hi_done;
    logic [6:0]  r_round;
    logic [2:0]  r_k;
    logic [6:0]  r_dbytes;

    logic [3:0]  clamp_cnt;
    logic [63:0] masked;
    logic [63:0] in_word;
    logic [63:0] pad_word;
    logic [63:0] wr_word;
    logic [63:0] add_n;
    logic [63:0] lo_sum;
    logic [63:0] sched_w;
    logic [63:0] t1, t2;
    logic [6:0]  cfg_clamped;
    logic [3:0]  nwords;
    logic [6:0]  remain;
    logic [3:0]  valid_b;

    always_comb begin
        clamp_cnt = (i_byte_count > WORD_BYTES) ? WORD_BYTES : i_byte_count;
        masked    = i_data_word & ~({64{1'b1}} >> {clamp_cnt, 3'b000});
        if (!i_last_of_message) begin
            in_word = i_data_word;
            add_n   = 64'd8;
        end else if (clamp_cnt < WORD_BYTES) begin
            in_word = masked | (PAD_WORD >> {clamp_cnt, 3'b000});
            add_n   = {60'd0, clamp_cnt};
        end else begin
            in_word = i_data_word;
            add_n   = 64'd8;
        end
        if (r_need80) begin
            pad_word = PAD_WORD;
        end else if (r_idx == IDX_LEN_HI) begin
            pad_word = {r_cnt_hi[60:0], r_cnt_lo[63:61]};
        end else if (r_idx == IDX_LEN_LO && r_hi_done) begin
            pad_word = {r_cnt_lo[60:0], 3'b000};
        end else begin
            pad_word = 64'd0;
        end
        wr_word = i_cmd.write_in ? in_word : pad_word;
        lo_sum  = r_cnt_lo + add_n;
    end

    always_comb begin
        if (r_round < 7'd16) begin
            sched_w = r_w[0];
        end else begin
            sched_w = ssig1(r_w[14]) + r_w[9] + ssig0(r_w[1]) + r_w[0];
        end
        t1 = r_v[7] + bsig1(r_v[4]) + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
           + round_k(r_round) + sched_w;
        t2 = bsig0(r_v[0]) + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.write_in || i_cmd.write_pad) begin
            for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
                r_w[i] <= r_w[i + 1];
            end
            r_w[BLOCK_WORDS - 1] <= wr_word;
        end else if (i_cmd.round) begin
            for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
                r_w[i] <= r_w[i + 1];
            end
            r_w[BLOCK_WORDS - 1] <= sched_w;
        end
        if (i_cmd.cinit) begin
            for (int i = 0; i < HASH_WORDS; i++) begin
                r_v[i] <= r_h[i];
            end
        end else if (i_cmd.round) begin
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
        end
    end

    always_comb begin
        if (i_cfg_digest_bytes > MAX_BYTES) begin
            cfg_clamped = MAX_BYTES;
        end else if (i_cfg_digest_bytes == 7'd0) begin
            cfg_clamped = 7'd1;
        end else begin
            cfg_clamped = i_cfg_digest_bytes;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.restart) begin
            for (int i = 0; i < HASH_WORDS; i++) begin
                r_h[i] <= IV[i];
            end
            r_cnt_hi  <= 64'd0;
            r_cnt_lo  <= 64'd0;
            r_idx     <= 4'd0;
            r_need80  <= 1'b0;
            r_hi_done <= 1'b0;
            r_round   <= 7'd0;
            r_k       <= 3'd0;
        end else begin
            if (i_cmd.write_in) begin
                r_cnt_lo <= lo_sum;
                r_cnt_hi <= r_cnt_hi + {63'd0, (lo_sum < add_n)};
                r_need80 <= i_last_of_message && (clamp_cnt == WORD_BYTES);
            end
            if (i_cmd.write_pad) begin
                if (r_need80) begin
                    r_need80 <= 1'b0;
                end else if (r_idx == IDX_LEN_HI) begin
                    r_hi_done <= 1'b1;
                end
            end
            if (i_cmd.write_in || i_cmd.write_pad) begin
                r_idx <= r_idx + 4'd1;
            end
            if (i_cmd.cinit) begin
                r_round <= 7'd0;
            end else if (i_cmd.round) begin
                r_round <= r_round + 7'd1;
            end
            if (i_cmd.cfin) begin
                for (int i = 0; i < HASH_WORDS; i++) begin
                    r_h[i] <= r_h[i] + r_v[i];
                end
            end
            if (i_cmd.take) begin
                r_k <= r_k + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dbytes <= MAX_BYTES;
        end else if (i_cfg_write) begin
            r_dbytes <= cfg_clamped;
        end
    end

    always_comb begin
        nwords  = 4'((r_dbytes + 7'd7) >> 3);
        remain  = r_dbytes - {1'b0, r_k, 3'b000};
        valid_b = (remain > 7'd8) ? WORD_BYTES : remain[3:0];
        o_digest_word        = r_h[r_k] & ~({64{1'b1}} >> {valid_b, 3'b000});
        o_digest_valid_bytes = valid_b;
        o_last_digest_word   = ({1'b0, r_k} + 4'd1 == nwords);
        o_status.idx_last    = (r_idx == IDX_LEN_LO);
        o_status.hi_done     = r_hi_done;
        o_status.round_last  = (r_round == LAST_ROUND);
        o_status.out_last    = o_last_digest_word;
    end

endmodule

/* src/sha512_hash_engine.sv */
// ----------------------------------------------------------------------------
// SHA-512 hash engine
// Streaming SHA-512 with padding and a truncated digest output.
// ----------------------------------------------------------------------------
// Message words enter on the data channel (valid/ready), big-endian, with a
// byte count and a last flag; only the last word may be partial. A word that
// fills a 128-byte block starts a compression (load, 80 rounds through the
// single round unit, chaining add), during which the data channel is not
// ready; otherwise it stays ready for the next word. After the last word
// the engine writes the padding words and runs one or two compressions.
// The digest then leaves on the digest channel as up to eight words, one
// per transaction, the final one marked; a stalled receiver holds the
// engine, and no new message word is taken until the last digest word is
// gone. The configuration channel sets the digest length in bytes and is
// always ready. Reset restores the initial hash value, clears the byte
// count and sets the digest length to 64 bytes.
// ----------------------------------------------------------------------------
module sha512_hash_engine
    import s512_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_data_valid,
    output logic        o_data_ready,
    input  logic [63:0] i_data_word,
    input  logic [3:0]  i_byte_count,
    input  logic        i_last_of_message,
    output logic        o_digest_valid,
    input  logic        i_digest_ready,
    output logic [63:0] o_digest_word,
    output logic [3:0]  o_digest_valid_bytes,
    output logic        o_last_digest_word,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [6:0]  i_cfg_digest_bytes
);

    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = 1'b1;

    s512_ctrl u_ctrl (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_data_valid      (i_data_valid),
        .i_last_of_message (i_last_of_message),
        .i_digest_ready    (i_digest_ready),
        .i_status          (status),
        .o_data_ready      (o_data_ready),
        .o_digest_valid    (o_digest_valid),
        .o_cmd             (cmd)
    );

    s512_datapath u_datapath (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cmd                (cmd),
        .i_data_word          (i_data_word),
        .i_byte_count         (i_byte_count),
        .i_last_of_message    (i_last_of_message),
        .i_cfg_write          (i_cfg_valid),
        .i_cfg_digest_bytes   (i_cfg_digest_bytes),
        .o_status             (status),
        .o_digest_word        (o_digest_word),
        .o_digest_valid_bytes (o_digest_valid_bytes),
        .o_last_digest_word   (o_last_digest_word)
    );

endmodule
